// ===== rtl/prw_pkg.sv =====
package prw_pkg;

   // Widths of the item fields, fixed by the block's interface.
   localparam int IDX_W    = 9;
   localparam int WEIGHT_W = 32;
   localparam int BETA_W   = 34;

   // Operation codes carried by req_opcode.
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_DRAW  = 2'd2;

   // Sequencer states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ADD  = 3'b010,
      ST_WALK = 3'b100
   } state_type;

endpackage

// ===== rtl/particle_resampling_wheel.sv =====
// Resampling-wheel particle selector. Load words (opcode 0) append one weight
// each to an internal store of MAX_PARTICLES entries; a load that arrives after
// drawing has begun starts a new weight set, and loads beyond a full store are
// dropped. A start word (opcode 1) places the wheel and clears the beta
// accumulator. A draw word (opcode 2) multiplies its random fraction by the
// largest loaded weight, adds twice that to beta, and then walks the wheel one
// stored weight per cycle through the single read port of the weight memory,
// subtracting each weight while beta exceeds it; busy stays high until the walk
// ends, and the result word is registered from that last walk step. The number
// of weights subtracted is bounded by about three trips around the loaded set.
// A start or draw with no weights loaded answers at once with empty_set high and
// index 0. The receiver cannot hold results off: each result word is valid for
// exactly the one cycle in which rsp_strobe is high, and must be taken then.
module particle_resampling_wheel #(
   parameter int MAX_PARTICLES = 512,
   parameter int RANDOM_BITS   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_opcode,
   input  logic [prw_pkg::WEIGHT_W-1:0]      req_weight_value,
   input  logic [prw_pkg::IDX_W-1:0]         req_start_index,
   input  logic [RANDOM_BITS-1:0]            req_random_fraction,
   output logic                              rsp_strobe,
   output logic [prw_pkg::IDX_W-1:0]         rsp_selected_index,
   output logic                              rsp_empty_set
);
   import prw_pkg::*;

   // Index width addresses the store; count width also holds the full count.
   localparam int IW     = $clog2(MAX_PARTICLES);
   localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
   localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int PROD_W = RANDOM_BITS + WEIGHT_W;
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_PARTICLES);

   // Weight store. Only entries below the loaded count are used by the walk.
   logic [WEIGHT_W-1:0] weight_mem [MAX_PARTICLES];

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [WEIGHT_W-1:0]  max_ff, max_in;
   logic [BETA_W-1:0]    beta_ff, beta_in;
   logic [IW-1:0]        wheel_ff, wheel_in;
   logic                 drawing_ff, drawing_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [WEIGHT_W-1:0]  rdata_ff;
   logic                 strobe_ff, strobe_in;
   logic [IDX_W-1:0]     sel_ff, sel_in;
   logic                 empty_ff, empty_in;

   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [CNT_W-1:0]     base_count;
   logic [WEIGHT_W-1:0]  base_max;
   logic [WEIGHT_W:0]    beta_inc;
   logic [CNT_W-1:0]     wheel_plus;
   logic                 walk_more;
   logic                 accept;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);

   // Twice the scaled fraction of the largest weight: drop one bit less than
   // the fraction's width.
   assign beta_inc   = prod_ff[PROD_W-1:RANDOM_BITS-1];
   assign wheel_plus = CNT_W'(wheel_ff) + CNT_W'(1);
   assign walk_more  = (beta_ff > BETA_W'(rdata_ff));

   // A load after drawing starts over from an empty set.
   assign base_count = drawing_ff ? '0 : count_ff;
   assign base_max   = drawing_ff ? '0 : max_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      max_in     = max_ff;
      beta_in    = beta_ff;
      wheel_in   = wheel_ff;
      drawing_in = drawing_ff;
      prod_in    = prod_ff;
      strobe_in  = 1'b0;
      sel_in     = sel_ff;
      empty_in   = empty_ff;
      wr_en      = 1'b0;
      wr_addr    = IW'(base_count);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_LOAD: begin
                     if (drawing_ff) begin
                        count_in   = '0;
                        max_in     = '0;
                        beta_in    = '0;
                        wheel_in   = '0;
                        drawing_in = 1'b0;
                     end
                     if (base_count < MAX_COUNT) begin
                        wr_en    = 1'b1;
                        count_in = base_count + CNT_W'(1);
                        max_in   = (req_weight_value > base_max) ? req_weight_value
                                                                 : base_max;
                     end
                  end
                  OP_START: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        sel_in    = '0;
                        empty_in  = 1'b1;
                     end else begin
                        wheel_in   = (CMP_W'(req_start_index) < CMP_W'(count_ff)) ?
                                     IW'(req_start_index) : '0;
                        beta_in    = '0;
                        drawing_in = 1'b1;
                     end
                  end
                  OP_DRAW: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        sel_in    = '0;
                        empty_in  = 1'b1;
                     end else begin
                        drawing_in = 1'b1;
                        prod_in    = PROD_W'(req_random_fraction) * PROD_W'(max_ff);
                        state_in   = ST_ADD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD: begin
            beta_in  = beta_ff + BETA_W'(beta_inc);
            wheel_in = (CNT_W'(wheel_ff) < count_ff) ? wheel_ff : '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            // The read data always belongs to the current wheel position.
            if (walk_more) begin
               beta_in  = beta_ff - BETA_W'(rdata_ff);
               wheel_in = (wheel_plus >= count_ff) ? '0 : IW'(wheel_plus);
            end else begin
               strobe_in = 1'b1;
               sel_in    = IDX_W'(wheel_ff);
               empty_in  = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory port: one write, and a registered read that follows the next
   // wheel position so the walk sees one weight per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         weight_mem[wr_addr] <= req_weight_value;
      end
      rdata_ff <= weight_mem[wheel_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         max_ff     <= '0;
         beta_ff    <= '0;
         wheel_ff   <= '0;
         drawing_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         max_ff     <= max_in;
         beta_ff    <= beta_in;
         wheel_ff   <= wheel_in;
         drawing_ff <= drawing_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sel_ff  <= sel_in;
      empty_ff <= empty_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_selected_index = sel_ff;
   assign rsp_empty_set      = empty_ff;

`ifndef SYNTHESIS
   // A draw only runs with weights loaded.
   a_busy_has_weights: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_ff != '0))
      else $error("draw in progress with no weights loaded");

   // The wheel never points past the loaded set.
   a_wheel_in_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (CNT_W'(wheel_ff) < count_ff))
      else $error("wheel index beyond loaded count");

   // The count never exceeds the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("weight count beyond store depth");

   // An empty-set answer always carries index zero.
   a_empty_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_empty_set) |-> (rsp_selected_index == '0))
      else $error("empty-set result with nonzero index");

   // The end of a walk produces exactly one non-empty result word.
   a_walk_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && !walk_more) |=> (rsp_strobe && !rsp_empty_set))
      else $error("walk ended without a result word");
`endif

endmodule
